// ===== hw/rtl/lswc_pkg.sv =====
// lswc_pkg: shared types and constants for the line sensor weighted centroid core
// no dependencies; imported by lswc_ctrl, lswc_dp and the top level
`default_nettype none

package lswc_pkg;

  localparam int NUM_CH        = 8;
  localparam int SAMPLE_W      = 8;
  localparam int FRAC_BITS_DEF = 8;
  localparam int SUM_W         = 11;  // up to 8 * 255
  localparam int WSUM_W        = 13;  // signed, magnitude up to 2550
  localparam int MAG_W         = 12;
  localparam int OFS_W         = 12;
  localparam int CNT_OUT_W     = 4;
  localparam logic [SAMPLE_W-1:0] GRAY_RESET = 8'd50;

  localparam logic signed [3:0] CH_WEIGHT [NUM_CH] = '{
    -4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd1, 4'sd2, 4'sd3, 4'sd4
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } lswc_state_t;

  typedef struct packed {
    logic load;  // capture frame
    logic sum;   // form sums, seed divider
    logic step;  // one restoring divide step
    logic fin;   // load output register
  } lswc_cmd_t;

  typedef struct packed {
    logic out_busy;  // output register holds an untaken beat
  } lswc_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lswc_ctrl.sv =====
// lswc_ctrl: sequencing state machine for the centroid core
// depends on lswc_pkg; drives lswc_dp through lswc_cmd_t
`default_nettype none

module lswc_ctrl
  import lswc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire lswc_stat_t stat,
  output lswc_cmd_t       cmd
);

  localparam int QW    = FRAC_BITS + 3;
  localparam int CNT_W = $clog2(QW);

  lswc_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (cnt_r == CNT_W'(QW - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lswc_dp.sv =====
// lswc_dp: frame capture, sums, restoring divider, saturation and output register
// depends on lswc_pkg; commanded by lswc_ctrl
`default_nettype none

module lswc_dp
  import lswc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lswc_cmd_t                    cmd,
  output lswc_stat_t                        stat,
  input  wire logic                         cfg_valid,
  input  wire logic [SAMPLE_W-1:0]          cfg_data,
  input  wire logic [NUM_CH*SAMPLE_W-1:0]   frame,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [OFS_W-1:0]                  out_offset,
  output logic                              out_lost,
  output logic [CNT_OUT_W-1:0]              out_count
);

  localparam int QW    = FRAC_BITS + 3;          // quotient bits, q <= 4 * 2^FRAC_BITS
  localparam int CW    = (QW > 13) ? QW : 13;    // compare width for saturation
  localparam int REM_W = SUM_W;

  logic [SAMPLE_W-1:0]  thr_r;
  logic [SAMPLE_W-1:0]  m_r [NUM_CH];
  logic [NUM_CH-1:0]    act_r;

  logic [SUM_W-1:0]     sum_r;
  logic                 neg_r;
  logic [CNT_OUT_W-1:0] cnt_r;
  logic [REM_W-1:0]     rem_r;
  logic [QW-1:0]        qd_r;

  logic [OFS_W-1:0]     held_r;
  logic                 out_valid_r;
  logic [OFS_W-1:0]     out_offset_r;
  logic                 out_lost_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= GRAY_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // frame capture with threshold masking
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NUM_CH; i++) begin
        act_r[i] <= frame[i*SAMPLE_W +: SAMPLE_W] > thr_r;
        m_r[i]   <= (frame[i*SAMPLE_W +: SAMPLE_W] > thr_r) ?
                    frame[i*SAMPLE_W +: SAMPLE_W] : '0;
      end
    end
  end

  // sums over the masked samples
  logic [SUM_W-1:0]         sum_c;
  logic signed [WSUM_W-1:0] wsum_c;
  logic [CNT_OUT_W-1:0]     cnt_c;
  logic [MAG_W-1:0]         mag_c;

  always_comb begin
    sum_c  = '0;
    wsum_c = '0;
    cnt_c  = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      sum_c  = sum_c + SUM_W'(m_r[i]);
      wsum_c = wsum_c + $signed({{(WSUM_W-SAMPLE_W){1'b0}}, m_r[i]})
                      * WSUM_W'(CH_WEIGHT[i]);
      cnt_c  = cnt_c + CNT_OUT_W'(act_r[i]);
    end
    mag_c = wsum_c[WSUM_W-1] ? MAG_W'(-wsum_c) : MAG_W'(wsum_c);
  end

  // restoring divide step: dividend bits leave the top of qd_r into the remainder, quotient enters below
  logic [REM_W:0] trial_c;
  logic           qbit_c;

  always_comb begin
    trial_c = {rem_r, qd_r[QW-1]};
    qbit_c  = trial_c >= (REM_W+1)'(sum_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_r <= sum_c;
      neg_r <= wsum_c[WSUM_W-1];
      cnt_r <= cnt_c;
      // top dividend bits are below sum, so they seed the remainder directly
      rem_r <= REM_W'(mag_c[MAG_W-1:3]);
      qd_r  <= {mag_c[2:0], {FRAC_BITS{1'b0}}};
    end else if (cmd.step) begin
      rem_r <= qbit_c ? REM_W'(trial_c - (REM_W+1)'(sum_r)) : REM_W'(trial_c);
      qd_r  <= {qd_r[QW-2:0], qbit_c};
    end
  end

  // sign and saturation, or the held offset when lost
  logic [CW-1:0]    qx_c;
  logic [CW-1:0]    qneg_c;
  logic [OFS_W-1:0] res_c;
  logic             lost_c;

  always_comb begin
    qx_c   = CW'(qd_r);
    qneg_c = -qx_c;
    lost_c = (cnt_r == '0) || (sum_r == '0);
    if (lost_c) begin
      res_c = held_r;
    end else if (neg_r) begin
      res_c = (qx_c > CW'(2048)) ? 12'h800 : qneg_c[OFS_W-1:0];
    end else begin
      res_c = (qx_c > CW'(2047)) ? 12'h7FF : qx_c[OFS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
        if (!lost_c) begin
          held_r <= res_c;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_offset_r <= res_c;
      out_lost_r   <= lost_c;
      out_count_r  <= cnt_r;
    end
  end

  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_offset    = out_offset_r;
  assign out_lost      = out_lost_r;
  assign out_count     = out_count_r;

endmodule

`default_nettype wire

// ===== hw/rtl/line_sensor_weighted_centroid_core.sv =====
// line_sensor_weighted_centroid_core: top level of the line position core
// depends on lswc_pkg, lswc_ctrl and lswc_dp
`default_nettype none

// Takes one frame of eight 8-bit reflectance samples per input beat and returns
// one result beat: the line offset as signed fixed point with FRAC_BITS fraction
// bits, the lost flag and the count of channels above the gray threshold. A
// channel is active when its sample is strictly above the threshold; the offset
// is the weighted sum (weights -4..-1, +1..+4 left to right) over the active
// samples divided by their plain sum, truncated toward zero and saturated to
// twelve bits. With no active channel the last good offset is repeated and lost
// is set. A frame goes through capture and threshold, forming both sums, a one-bit
// restoring divider over FRAC_BITS + 3 quotient bits, and saturation with the load
// of the output register; the next frame is accepted only once the core is back
// in idle. The output register lets the next frame be taken while a result beat
// still waits; the finish step stalls only while the previous result is still
// untaken. The threshold register resets to 50 and is written through the cfg
// channel, which is always ready.

module line_sensor_weighted_centroid_core
  import lswc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF  // 4..16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input frame channel
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [NUM_CH*SAMPLE_W-1:0] in_tdata,   // ch_0 [7:0] .. ch_7 [63:56]
  // result channel
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [15:0]                     out_tdata,  // offset [11:0], lit_count [15:12]
  output logic                            out_tuser,  // lost
  // threshold write channel
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [SAMPLE_W-1:0]        cfg_data    // gray_threshold
);

  lswc_cmd_t            cmd;
  lswc_stat_t           stat;
  logic [OFS_W-1:0]     offset;
  logic [CNT_OUT_W-1:0] lit_count;

  // threshold writes are taken at any time
  assign cfg_ready = 1'b1;

  // sequencer: capture, sum, divide, finish
  lswc_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath with held offset and output register
  lswc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .frame      (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_offset (offset),
    .out_lost   (out_tuser),
    .out_count  (lit_count)
  );

  // pack result fields, offset in the low bits
  assign out_tdata = {lit_count, offset};

endmodule

`default_nettype wire

// ===== bench/lswc_centroid_checker.sv =====
// lswc_centroid_checker: watches the frame, result and threshold channels of the
// line sensor centroid core, predicts each result beat and compares it field by field
// depends on lswc_pkg for widths and the threshold reset value
module lswc_centroid_checker
  import lswc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  input  wire logic                       in_tready,
  input  wire logic [NUM_CH*SAMPLE_W-1:0] in_tdata,   // ch_0 [7:0] .. ch_7 [63:56]
  input  wire logic                       out_tvalid,
  input  wire logic                       out_tready,
  input  wire logic [15:0]                out_tdata,  // offset [11:0], lit_count [15:12]
  input  wire logic                       out_tuser,  // lost
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_ready,
  input  wire logic [SAMPLE_W-1:0]        cfg_data,   // gray_threshold
  output int                              mismatches,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint OFS_TOP = 2 ** (OFS_W - 1) - 1;
  localparam longint OFS_BOT = -(2 ** (OFS_W - 1));

  typedef struct packed {
    logic [OFS_W-1:0]     offset;
    logic                 lost;
    logic [CNT_OUT_W-1:0] lit_count;
  } line_fix_t;

  line_fix_t           expected_fixes[$];
  logic [SAMPLE_W-1:0] gray_level;
  logic [OFS_W-1:0]    last_offset;

  // weighted centroid of one frame; held offset comes back when nothing is active
  function automatic line_fix_t locate_line(input logic [NUM_CH*SAMPLE_W-1:0] frame,
                                            input logic [SAMPLE_W-1:0] gray,
                                            input logic [OFS_W-1:0] held);
    line_fix_t fix;
    int        weighted;
    int        total;
    int        hits;
    int        sample;
    int        weight;
    longint    mag;
    longint    quo;
    weighted = 0;
    total    = 0;
    hits     = 0;
    for (int i = 0; i < NUM_CH; i++) begin
      sample = int'(frame[i*SAMPLE_W +: SAMPLE_W]);
      // -4..-1 on the left half, +1..+4 on the right half
      weight = (i < NUM_CH / 2) ? i - NUM_CH / 2 : i - NUM_CH / 2 + 1;
      if (sample > int'(gray)) begin
        weighted += weight * sample;
        total    += sample;
        hits++;
      end
    end
    if (hits == 0 || total == 0) begin
      fix.offset = held;
      fix.lost   = 1'b1;
    end else begin
      mag = (weighted < 0) ? -longint'(weighted) : longint'(weighted);
      quo = (mag << FRAC_BITS) / longint'(total);
      if (weighted < 0) quo = -quo;
      if (quo > OFS_TOP) quo = OFS_TOP;
      else if (quo < OFS_BOT) quo = OFS_BOT;
      fix.offset = quo[OFS_W-1:0];
      fix.lost   = 1'b0;
    end
    fix.lit_count = hits[CNT_OUT_W-1:0];
    return fix;
  endfunction

  always @(posedge clk) begin : watch
    line_fix_t fix;
    line_fix_t want;
    if (!rst_n) begin
      expected_fixes.delete();
      mismatches   = 0;
      gray_level  <= GRAY_RESET;
      last_offset <= '0;
      outstanding <= 0;
    end else begin
      // retire first so a beat can never match a frame taken at the same edge
      if (out_tvalid && out_tready) begin
        if (expected_fixes.size() == 0) begin
          $error("result beat with nothing expected: tdata %h tuser %b", out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = expected_fixes.pop_front();
          if (out_tdata[OFS_W-1:0] !== want.offset) begin
            $error("offset: expected %0d actual %0d", $signed(want.offset),
                   $signed(out_tdata[OFS_W-1:0]));
            mismatches++;
          end
          if (out_tuser !== want.lost) begin
            $error("lost: expected %b actual %b", want.lost, out_tuser);
            mismatches++;
          end
          if (out_tdata[15:12] !== want.lit_count) begin
            $error("lit_count: expected %0d actual %0d", want.lit_count,
                   out_tdata[15:12]);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) gray_level <= cfg_data;
      if (in_tvalid && in_tready) begin
        fix = locate_line(in_tdata, gray_level, last_offset);
        expected_fixes.push_back(fix);
        if (!fix.lost) last_offset <= fix.offset;
      end
      outstanding <= expected_fixes.size();
    end
  end

endmodule

// ===== bench/line_sensor_weighted_centroid_core_test.sv =====
// line_sensor_weighted_centroid_core_test: stimulus and verdict for the line position core
// depends on lswc_pkg, line_sensor_weighted_centroid_core and lswc_centroid_checker
module line_sensor_weighted_centroid_core_test
  import lswc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_W    = NUM_CH * SAMPLE_W;
  localparam int NUM_PHASES = 7;
  localparam int PHASE_LEN  = 150;  // frames per threshold setting in the random part

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [FRAME_W-1:0]    in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [SAMPLE_W-1:0]   cfg_data   = '0;
  int                    mismatches;
  int                    outstanding;

  // threshold currently in the core, used to shape random frames around it
  int gray_now   = int'(GRAY_RESET);
  // remaining beats of a stretch with no idle cycles on the sender
  int quiet_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_sensor_weighted_centroid_core #(
    .FRAC_BITS (FRAC_BITS_DEF)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  lswc_centroid_checker #(
    .FRAC_BITS (FRAC_BITS_DEF)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // offer one frame beat after a random idle gap, return at the edge it is taken
  task automatic send_frame(input logic [FRAME_W-1:0] frame);
    int gap;
    if (quiet_left > 0) begin
      gap = 0;
      quiet_left--;
    end else begin
      gap = $urandom_range(10, 0);
      // now and then a run of back-to-back beats
      if ($urandom_range(19, 0) == 0) quiet_left = $urandom_range(40, 10);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= frame;
    do @(posedge clk); while (!in_tready);
  endtask

  // hold the sender off until every expected result beat has been taken
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    // then a further idle wait before the caller goes on
    repeat (FRAC_BITS_DEF + 8) @(posedge clk);
  endtask

  // threshold write, only called with the core idle
  task automatic write_gray(input int level);
    cfg_valid <= 1'b1;
    cfg_data  <= SAMPLE_W'(level);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gray_now = level;
  endtask

  // random frame: mostly a mix of bright, dark, full-range and near-threshold
  // channels, sometimes a frame with every channel at or below the threshold
  function automatic logic [FRAME_W-1:0] random_frame(input int gray);
    logic [FRAME_W-1:0] frame;
    int                 lo;
    int                 hi;
    bit                 dark;
    dark = ($urandom_range(7, 0) == 0);
    lo   = (gray > 2) ? gray - 2 : 0;
    hi   = (gray < 253) ? gray + 2 : 255;
    for (int i = 0; i < NUM_CH; i++) begin
      if (dark) begin
        frame[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(gray, 0));
      end else begin
        case ($urandom_range(3, 0))
          0: frame[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(255, 0));
          1: frame[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(hi, lo));
          2: frame[i*SAMPLE_W +: SAMPLE_W] = '0;
          default: frame[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(255, 200));
        endcase
      end
    end
    return frame;
  endfunction

  // result side: random stall before each beat, with occasional stretches of none
  initial begin : result_sink
    int hold;
    int calm;
    calm = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (calm > 0) begin
        hold = 0;
        calm--;
      end else begin
        hold = $urandom_range(10, 0);
        if ($urandom_range(15, 0) == 0) calm = $urandom_range(40, 10);
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // hard stop well past the slowest correct run
  initial begin : watchdog
    #4ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int phase_gray[NUM_PHASES];
    // a mid value first, then the extremes near 0 and 255, and two random settings
    phase_gray = '{128, 0, 255, 254, 1, 50, 50};
    phase_gray[5] = $urandom_range(255, 0);
    phase_gray[6] = $urandom_range(200, 20);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames at the reset threshold of 50
    send_frame('0);                             // nothing active right after reset: held zero
    send_frame({NUM_CH{8'd50}});                // equal to threshold does not count
    send_frame({NUM_CH{8'd51}});                // all active, balanced weights
    send_frame(64'h0000_0000_0000_00FF);        // leftmost only: full left
    send_frame(64'hFF00_0000_0000_0000);        // rightmost only: full right
    send_frame('0);                             // lost, repeats full right
    send_frame({NUM_CH{8'hFF}});                // all saturated bright
    send_frame(64'h0000_0000_0000_FF33);        // negative quotient truncated toward zero
    send_frame(64'h33FF_0000_0000_0000);        // positive quotient truncated toward zero
    send_frame(64'hFF00_FF00_FF00_FF00);
    send_frame(64'h00FF_00FF_00FF_00FF);
    send_frame(64'h0000_00FF_FF00_0000);        // center pair
    drain_results();

    // lowest threshold: any nonzero sample is active
    write_gray(0);
    send_frame('0);                             // lost, holds the last good offset
    send_frame({NUM_CH{8'd1}});
    send_frame(64'h0000_0000_0000_0001);
    drain_results();

    // highest threshold: nothing can ever be active
    write_gray(255);
    send_frame({NUM_CH{8'hFF}});
    drain_results();

    write_gray(254);
    send_frame({NUM_CH{8'hFF}});
    send_frame(64'hFF00_0000_0000_00FE);        // only rightmost clears 254
    drain_results();

    // random part, one threshold setting per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_gray(phase_gray[p]);
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_frame(random_frame(gray_now));
        // mid-phase pause until the core has emptied out
        if (n == PHASE_LEN / 2) drain_results();
      end
      drain_results();
    end

    // quiet tail for anything still in flight
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
